// ===== hw/rtl/ndl_pkg.sv =====
// ----------------------------------------------------------------------------
// ndl_pkg
// Shared constants and types for the N-D index linearizer.
// ----------------------------------------------------------------------------
package ndl_pkg;

    localparam int LIN_W      = 48;
    localparam int IDX_W      = 12;
    localparam int NUM_FIELDS = 4;
    localparam int DIMS_W     = 3;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;

    localparam int MAX_DIMS_DEF    = 4;
    localparam int EXTENT_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3 = 3'd4;

    typedef logic [NUM_FIELDS-1:0][IDX_W-1:0] t_idx_arr;

    typedef struct packed {
        logic valid;
        logic func;
        logic err;
    } t_ctl;

endpackage

// ===== hw/rtl/ndl_if.sv =====
// ----------------------------------------------------------------------------
// ndl_req_if / ndl_rsp_if
// Valid/ready channels for index tuples and results.
// ----------------------------------------------------------------------------
interface ndl_req_if;
    import ndl_pkg::*;
    logic             valid;
    logic             ready;
    logic             func;
    logic [IDX_W-1:0] index_0;
    logic [IDX_W-1:0] index_1;
    logic [IDX_W-1:0] index_2;
    logic [IDX_W-1:0] index_3;
    logic [LIN_W-1:0] linear_in;

    modport source (output valid, func, index_0, index_1, index_2, index_3, linear_in,
                    input ready);
    modport sink   (input valid, func, index_0, index_1, index_2, index_3, linear_in,
                    output ready);
endinterface

interface ndl_rsp_if;
    import ndl_pkg::*;
    logic             valid;
    logic             ready;
    logic [LIN_W-1:0] linear_out;
    logic [IDX_W-1:0] coord_0;
    logic [IDX_W-1:0] coord_1;
    logic [IDX_W-1:0] coord_2;
    logic [IDX_W-1:0] coord_3;
    logic             range_error;

    modport source (output valid, linear_out, coord_0, coord_1, coord_2, coord_3,
                    range_error, input ready);
    modport sink   (input valid, linear_out, coord_0, coord_1, coord_2, coord_3,
                    range_error, output ready);
endinterface

// ===== hw/rtl/ndl_mac_cell.sv =====
// ----------------------------------------------------------------------------
// ndl_mac_cell
// One forward stage: range check of one index and multiply-add fold.
// ----------------------------------------------------------------------------
module ndl_mac_cell #(
    parameter int EXTENT_BITS = ndl_pkg::EXTENT_BITS_DEF,
    parameter int DIM         = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  ndl_pkg::t_ctl             i_ctl,
    input  logic [ndl_pkg::LIN_W-1:0] i_lin,
    input  ndl_pkg::t_idx_arr         i_idx,
    input  logic                      i_used,
    input  logic [EXTENT_BITS:0]      i_ext,
    output ndl_pkg::t_ctl             o_ctl,
    output logic [ndl_pkg::LIN_W-1:0] o_lin,
    output ndl_pkg::t_idx_arr         o_idx
);
    import ndl_pkg::*;

    localparam int EXT_W = EXTENT_BITS + 1;
    localparam int CMP_W = (EXT_W > IDX_W) ? EXT_W : IDX_W;

    logic                   active;
    logic [LIN_W+EXT_W-1:0] prod;
    logic [LIN_W-1:0]       n_lin;
    logic                   n_err;
    logic                   r_valid;
    logic                   r_func;
    logic                   r_err;
    logic [LIN_W-1:0]       r_lin;
    t_idx_arr               r_idx;

    assign active = !i_ctl.func && i_used;
    assign prod   = i_lin * i_ext;

    always_comb begin
        n_lin = i_lin;
        n_err = i_ctl.err;
        if (active) begin
            n_err = i_ctl.err || (CMP_W'(i_idx[DIM]) >= CMP_W'(i_ext));
            if (DIM == 0) begin
                n_lin = LIN_W'(i_idx[DIM]);
            end else begin
                n_lin = prod[LIN_W-1:0] + LIN_W'(i_idx[DIM]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_func <= i_ctl.func;
            r_err  <= n_err;
            r_lin  <= n_lin;
            r_idx  <= i_idx;
        end
    end

    assign o_ctl = '{valid: r_valid, func: r_func, err: r_err};
    assign o_lin = r_lin;
    assign o_idx = r_idx;

endmodule

// ===== hw/rtl/ndl_div_cell.sv =====
// ----------------------------------------------------------------------------
// ndl_div_cell
// One restoring-division bit step of the reverse conversion.
// ----------------------------------------------------------------------------
module ndl_div_cell #(
    parameter int EXTENT_BITS = ndl_pkg::EXTENT_BITS_DEF,
    parameter int DIM         = 0,
    parameter bit LAST        = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  ndl_pkg::t_ctl             i_ctl,
    input  logic [ndl_pkg::LIN_W-1:0] i_lin,
    input  logic [EXTENT_BITS-1:0]    i_rem,
    input  ndl_pkg::t_idx_arr         i_coord,
    input  logic                      i_used,
    input  logic [EXTENT_BITS:0]      i_ext,
    output ndl_pkg::t_ctl             o_ctl,
    output logic [ndl_pkg::LIN_W-1:0] o_lin,
    output logic [EXTENT_BITS-1:0]    o_rem,
    output ndl_pkg::t_idx_arr         o_coord
);
    import ndl_pkg::*;

    logic                   active;
    logic [EXTENT_BITS:0]   trial;
    logic [EXTENT_BITS:0]   diff;
    logic                   ge;
    logic [LIN_W-1:0]       n_lin;
    logic [EXTENT_BITS-1:0] n_rem;
    t_idx_arr               n_coord;
    logic                   r_valid;
    logic                   r_func;
    logic                   r_err;
    logic [LIN_W-1:0]       r_lin;
    logic [EXTENT_BITS-1:0] r_rem;
    t_idx_arr               r_coord;

    assign active = i_ctl.func && i_used;
    assign trial  = {i_rem, i_lin[LIN_W-1]};
    assign ge     = trial >= i_ext;
    assign diff   = ge ? (trial - i_ext) : trial;

    always_comb begin
        n_lin   = i_lin;
        n_rem   = i_rem;
        n_coord = i_coord;
        if (active) begin
            n_lin = {i_lin[LIN_W-2:0], ge};
            n_rem = diff[EXTENT_BITS-1:0];
            if (LAST) begin
                n_coord[DIM] = IDX_W'(diff[EXTENT_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_func  <= i_ctl.func;
            r_err   <= i_ctl.err;
            r_lin   <= n_lin;
            r_rem   <= n_rem;
            r_coord <= n_coord;
        end
    end

    assign o_ctl   = '{valid: r_valid, func: r_func, err: r_err};
    assign o_lin   = r_lin;
    assign o_rem   = r_rem;
    assign o_coord = r_coord;

endmodule

// ===== hw/rtl/nd_index_linearizer.sv =====
// Throughput: one transaction per cycle; the whole cell chain advances together and
// stalls only while a finished result waits at the output.
// The chain is D = min(MAX_DIMS, 4) multiply-add cells followed by D*48 one-bit division cells.
// Reset (synchronous, active low) empties the chain and sets num_dims and extents to 1.
// ----------------------------------------------------------------------------
// nd_index_linearizer
// Row-major index linearization and its inverse over a chain of cells.
// ----------------------------------------------------------------------------
module nd_index_linearizer #(
    parameter int MAX_DIMS    = ndl_pkg::MAX_DIMS_DEF,
    parameter int EXTENT_BITS = ndl_pkg::EXTENT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ndl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ndl_pkg::CFG_W-1:0]     i_cfg_data,
    ndl_req_if.sink                       i_req,
    ndl_rsp_if.source                     o_rsp
);
    import ndl_pkg::*;

    localparam int NDIM  = (MAX_DIMS < NUM_FIELDS) ? MAX_DIMS : NUM_FIELDS;
    localparam int NDIV  = NDIM * LIN_W;
    localparam int EXT_W = EXTENT_BITS + 1;

    logic [DIMS_W-1:0]     r_num_dims;
    logic [CFG_W-1:0]      r_extent [NUM_FIELDS];
    logic [DIMS_W-1:0]     used_cnt;
    logic [NUM_FIELDS-1:0] used;
    logic [EXT_W-1:0]      eff_ext [NUM_FIELDS];
    logic                  adv;

    t_ctl                   mc  [NDIM+1];
    logic [LIN_W-1:0]       ml  [NDIM+1];
    t_idx_arr               mi  [NDIM+1];
    t_ctl                   dc  [NDIV+1];
    logic [LIN_W-1:0]       dl  [NDIV+1];
    logic [EXTENT_BITS-1:0] dr  [NDIV+1];
    t_idx_arr               dco [NDIV+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= DIMS_W'(1);
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_extent[k] <= CFG_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_DIMS: r_num_dims  <= i_cfg_data[DIMS_W-1:0];
                REG_EXTENT_0: r_extent[0] <= i_cfg_data;
                REG_EXTENT_1: r_extent[1] <= i_cfg_data;
                REG_EXTENT_2: r_extent[2] <= i_cfg_data;
                REG_EXTENT_3: r_extent[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_num_dims == '0) begin
            used_cnt = DIMS_W'(1);
        end else if (32'(r_num_dims) > NDIM) begin
            used_cnt = DIMS_W'(NDIM);
        end else begin
            used_cnt = r_num_dims;
        end
        for (int k = 0; k < NUM_FIELDS; k++) begin
            used[k] = k < 32'(used_cnt);
            priority if (r_extent[k] == '0) begin
                eff_ext[k] = EXT_W'(1);
            end else if (32'(r_extent[k]) > (32'd1 << EXTENT_BITS)) begin
                eff_ext[k] = EXT_W'(32'd1 << EXTENT_BITS);
            end else begin
                eff_ext[k] = EXT_W'(r_extent[k]);
            end
        end
    end

    assign adv         = !dc[NDIV].valid || o_rsp.ready;
    assign i_req.ready = adv;

    assign mc[0]    = '{valid: i_req.valid, func: i_req.func, err: 1'b0};
    assign ml[0]    = i_req.func ? i_req.linear_in : '0;
    assign mi[0][0] = i_req.index_0;
    assign mi[0][1] = i_req.index_1;
    assign mi[0][2] = i_req.index_2;
    assign mi[0][3] = i_req.index_3;

    for (genvar k = 0; k < NDIM; k++) begin : g_mac
        ndl_mac_cell #(
            .EXTENT_BITS (EXTENT_BITS),
            .DIM         (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (mc[k]),
            .i_lin   (ml[k]),
            .i_idx   (mi[k]),
            .i_used  (used[k]),
            .i_ext   (eff_ext[k]),
            .o_ctl   (mc[k+1]),
            .o_lin   (ml[k+1]),
            .o_idx   (mi[k+1])
        );
    end

    assign dc[0]  = mc[NDIM];
    assign dl[0]  = ml[NDIM];
    assign dr[0]  = '0;
    assign dco[0] = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        localparam int GRP = g / LIN_W;
        localparam int BIT = g % LIN_W;
        localparam int DK  = NDIM - 1 - GRP;
        logic [EXTENT_BITS-1:0] rem_in;
        assign rem_in = (BIT == 0) ? '0 : dr[g];
        ndl_div_cell #(
            .EXTENT_BITS (EXTENT_BITS),
            .DIM         (DK),
            .LAST        (BIT == LIN_W - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (dc[g]),
            .i_lin   (dl[g]),
            .i_rem   (rem_in),
            .i_coord (dco[g]),
            .i_used  (used[DK]),
            .i_ext   (eff_ext[DK]),
            .o_ctl   (dc[g+1]),
            .o_lin   (dl[g+1]),
            .o_rem   (dr[g+1]),
            .o_coord (dco[g+1])
        );
    end

    assign o_rsp.valid       = dc[NDIV].valid;
    assign o_rsp.linear_out  = (!dc[NDIV].func && !dc[NDIV].err) ? dl[NDIV] : '0;
    assign o_rsp.coord_0     = dc[NDIV].func ? dco[NDIV][0] : '0;
    assign o_rsp.coord_1     = dc[NDIV].func ? dco[NDIV][1] : '0;
    assign o_rsp.coord_2     = dc[NDIV].func ? dco[NDIV][2] : '0;
    assign o_rsp.coord_3     = dc[NDIV].func ? dco[NDIV][3] : '0;
    assign o_rsp.range_error = !dc[NDIV].func && dc[NDIV].err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.range_error |-> o_rsp.linear_out == '0)
        else $error("range error with nonzero linear number");

    a_coord_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.coord_0 != '0 || o_rsp.coord_1 != '0 ||
         o_rsp.coord_2 != '0 || o_rsp.coord_3 != '0)
        |-> !o_rsp.range_error && o_rsp.linear_out == '0)
        else $error("forward and reverse results mixed");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("request taken while chain stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/tb_nd_index_linearizer.sv =====
// ----------------------------------------------------------------------------
// tb_nd_index_linearizer
// Self-checking bench for the row-major index linearizer. It drives forward
// and reverse transactions over several register settings and compares every
// result with a cycle-free model of the index fold and its inverse.
// ----------------------------------------------------------------------------
module tb_nd_index_linearizer;
    import ndl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic FUNC_FOLD   = 1'b0;
    localparam logic FUNC_UNFOLD = 1'b1;
    localparam int   DRAIN_CYC   = 250;

    typedef struct {
        logic [LIN_W-1:0] lin;
        logic [IDX_W-1:0] coord [NUM_FIELDS];
        logic             err;
    } t_result;

    class linear_scoreboard;
        logic [DIMS_W-1:0] dims_reg;
        logic [CFG_W-1:0]  extent_reg [NUM_FIELDS];
        t_result           expected_q [$];
        int                errors;
        int                checked;
        int                n_err_seen;
        int                n_unfold;

        function void reset_regs();
            dims_reg = 1;
            foreach (extent_reg[k]) extent_reg[k] = 1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_NUM_DIMS) dims_reg = data[DIMS_W-1:0];
            else if (idx >= REG_EXTENT_0 && idx <= REG_EXTENT_3)
                extent_reg[idx - REG_EXTENT_0] = data;
        endfunction

        function int used_dims();
            int d;
            d = dims_reg;
            if (d < 1) d = 1;
            if (d > NUM_FIELDS) d = NUM_FIELDS;
            return d;
        endfunction

        function longint unsigned eff_extent(int k);
            longint unsigned e;
            e = extent_reg[k];
            if (e < 1) e = 1;
            if (e > (64'd1 << IDX_W)) e = 64'd1 << IDX_W;
            return e;
        endfunction

        function void note_input(logic func, logic [IDX_W-1:0] idx [NUM_FIELDS],
                                 logic [LIN_W-1:0] lin_in);
            t_result r;
            longint unsigned acc, n, e;
            int d;
            d = used_dims();
            r.lin = '0;
            r.err = 1'b0;
            foreach (r.coord[k]) r.coord[k] = '0;
            if (func == FUNC_FOLD) begin
                for (int k = 0; k < d; k++)
                    if (idx[k] >= eff_extent(k)) r.err = 1'b1;
                if (!r.err) begin
                    acc = idx[0];
                    for (int k = 1; k < d; k++) acc = acc * eff_extent(k) + idx[k];
                    r.lin = acc[LIN_W-1:0];
                end
            end else begin
                n = lin_in;
                for (int k = d - 1; k >= 0; k--) begin
                    e = eff_extent(k);
                    r.coord[k] = IDX_W'(n % e);
                    n = n / e;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result act);
            t_result ex;
            checked++;
            if (act.err) n_err_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result lin=%h err=%b", $time, act.lin, act.err);
                errors++;
                return;
            end
            ex = expected_q.pop_front();
            if (ex.lin !== act.lin) begin
                $display("%0t: linear_out exp %h got %h", $time, ex.lin, act.lin);
                errors++;
            end
            foreach (ex.coord[k])
                if (ex.coord[k] !== act.coord[k]) begin
                    $display("%0t: coord_%0d exp %h got %h", $time, k, ex.coord[k],
                             act.coord[k]);
                    errors++;
                end
            if (ex.err !== act.err) begin
                $display("%0t: range_error exp %b got %b", $time, ex.err, act.err);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;

    ndl_req_if req_if ();
    ndl_rsp_if rsp_if ();

    nd_index_linearizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    linear_scoreboard sb;
    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_req;
    int  hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    // sink side: random back-pressure plus a single long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result act;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            act.lin      = rsp_if.linear_out;
            act.coord[0] = rsp_if.coord_0;
            act.coord[1] = rsp_if.coord_1;
            act.coord[2] = rsp_if.coord_2;
            act.coord[3] = rsp_if.coord_3;
            act.err      = rsp_if.range_error;
            sb.check_result(act);
        end
    end

    task automatic send_item(logic func, logic [IDX_W-1:0] idx [NUM_FIELDS],
                             logic [LIN_W-1:0] lin_in);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= func;
        req_if.index_0   <= idx[0];
        req_if.index_1   <= idx[1];
        req_if.index_2   <= idx[2];
        req_if.index_3   <= idx[3];
        req_if.linear_in <= lin_in;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_input(func, idx, lin_in);
        if (func == FUNC_UNFOLD) sb.n_unfold++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_W-1:0] dims, logic [CFG_W-1:0] e0,
                             logic [CFG_W-1:0] e1, logic [CFG_W-1:0] e2,
                             logic [CFG_W-1:0] e3);
        logic [CFG_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0] regs [5];
        vals = '{dims, e0, e1, e2, e3};
        regs = '{REG_NUM_DIMS, REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_reg(regs[i], vals[i]);
        end
        i_cfg_idx  <= REG_UNMAPPED;
        i_cfg_data <= CFG_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic longint unsigned used_product();
        longint unsigned p;
        p = 1;
        for (int k = 0; k < sb.used_dims(); k++) p *= sb.eff_extent(k);
        return p;
    endfunction

    task automatic random_items(int count);
        logic [IDX_W-1:0] idx [NUM_FIELDS];
        logic [LIN_W-1:0] lin;
        longint unsigned  p, e;
        int r;
        for (int i = 0; i < count; i++) begin
            foreach (idx[k]) begin
                e = sb.eff_extent(k);
                r = $urandom_range(9);
                if (r < 7)      idx[k] = IDX_W'($urandom_range(int'(e) - 1, 0));
                else if (r < 9) idx[k] = IDX_W'(e - $urandom_range(1, 0));
                else            idx[k] = IDX_W'($urandom);
            end
            p = used_product();
            r = $urandom_range(9);
            if (r < 6)       lin = LIN_W'({$urandom, $urandom} % p);
            else if (r == 6) lin = LIN_W'(p - 1);
            else             lin = LIN_W'({$urandom, $urandom});
            send_item(1'($urandom_range(1)), idx, lin);
        end
    endtask

    task automatic directed_items();
        logic [IDX_W-1:0] idx [NUM_FIELDS];
        logic [IDX_W-1:0] zero4 [NUM_FIELDS];
        zero4 = '{default: '0};
        send_item(FUNC_FOLD, zero4, '1);
        idx = '{default: '1};
        send_item(FUNC_FOLD, idx, '0);
        idx = '{12'd1, 12'd2, 12'd3, 12'd4};
        send_item(FUNC_FOLD, idx, '0);
        send_item(FUNC_UNFOLD, idx, '0);
        send_item(FUNC_UNFOLD, idx, '1);
        send_item(FUNC_UNFOLD, zero4, 48'h0000_0100_0001);
        send_item(FUNC_UNFOLD, zero4, 48'h8000_0000_0000);
        send_item(FUNC_UNFOLD, zero4, 48'h5555_5555_5555);
        send_item(FUNC_UNFOLD, zero4, 48'hAAAA_AAAA_AAAA);
    endtask

    initial begin
        logic [IDX_W-1:0] idx [NUM_FIELDS];
        sb = new();
        sb.reset_regs();
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.func  = 1'b0;
        req_if.index_0 = '0;
        req_if.index_1 = '0;
        req_if.index_2 = '0;
        req_if.index_3 = '0;
        req_if.linear_in = '0;
        rsp_if.ready = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b0;
        hold_cnt     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one dimension of extent one
        idx = '{12'd0, 12'd7, 12'd9, 12'd4095};
        send_item(FUNC_FOLD, idx, '0);
        idx[0] = 12'd1;
        send_item(FUNC_FOLD, idx, '0);
        send_item(FUNC_UNFOLD, idx, 48'h1234_5678_9ABC);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_cfg(4, 4096, 4096, 4096, 4096);
                1: write_cfg(7, 8191, 0, 4097, 1);
                2: write_cfg(2, 37, 4096, 1, 1);
                3: write_cfg(3, 5, 1, 4000, 9);
                4: write_cfg(0, 300, 17, 5, 6);
                5: write_cfg(5, 3, 5, 7, 2);
                default: write_cfg(1, 4096, 8, 8, 8);
            endcase
            case (ph % 3)
                0: begin src_idle_pct = 26; snk_idle_pct = 58; end
                1: begin src_idle_pct = 58; snk_idle_pct = 26; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            if (ph < 2) directed_items();
            if (ph == 2) hold_req = 1'b1;
            random_items(270);
            drain();
        end

        $display("covered %0d results (%0d reverse, %0d range errors) over 8 settings",
                 sb.checked, sb.n_unfold, sb.n_err_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/ndl_pkg.sv
hw/rtl/ndl_if.sv
hw/rtl/ndl_mac_cell.sv
hw/rtl/ndl_div_cell.sv
hw/rtl/nd_index_linearizer.sv
tb/tb_nd_index_linearizer.sv
